// ===== design/hrrp_pkg.sv =====
package hrrp_pkg;

  localparam int HEADER_END_COUNT_DEF = 4;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    PH_G     = 4'd0,
    PH_E     = 4'd1,
    PH_T     = 4'd2,
    PH_SP    = 4'd3,
    PH_SLASH = 4'd4,
    PH_ROUTE = 4'd5,
    PH_LED0  = 4'd6,
    PH_LED1  = 4'd7,
    PH_HDR   = 4'd8,
    PH_WAIT  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ROUTE_MAIN      = 2'd0,
    ROUTE_REDIRECT  = 2'd1,
    ROUTE_NOT_FOUND = 2'd2,
    ROUTE_STATUS    = 2'd3
  } route_t;

  function automatic logic is_newline(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ===== design/http_request_route_parser.sv =====
// HTTP request route parser.
// The input channel carries one item per event: either a received byte
// (in_kind low, in_data_byte valid) or a transmitter status sample (in_kind
// high, in_tx_busy_level valid). Every accepted item produces exactly one
// result item on the output channel, carrying the current route, the two LED
// levels and a start pulse flag that is high only for the byte that ended the
// request headers.
// The result is registered: an item accepted at a clock edge has its result in
// the result register straight after that edge, where it waits to be taken.
// One item is accepted per cycle while in_stall is low, with only the single
// state update done between the input handshake and the result register.
// The result register forms the only buffer. While a result waits under
// out_stall, in_stall is raised; once it is taken, a new item may be accepted
// in the same cycle, so throughput stays at one item per cycle.
// Synchronous reset (rst_n low) returns the parser to waiting for the first
// letter of the request, clears the route, both LEDs and the newline run, and
// empties the result register.
module http_request_route_parser
  import hrrp_pkg::*;
#(
  parameter int HEADER_END_COUNT = HEADER_END_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  input  logic       in_tx_busy_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_route,
  output logic       out_led_zero,
  output logic       out_led_one,
  output logic       out_start_pulse
);

  localparam logic [3:0] END_COUNT = 4'(HEADER_END_COUNT);

  phase_t     phase_r, phase_nxt;
  logic [2:0] run_r, run_nxt;
  route_t     route_r, route_nxt;
  logic       led0_r, led0_nxt;
  logic       led1_r, led1_nxt;
  logic       start_r, start_nxt;
  logic       out_valid_r;
  logic       accept;
  logic [3:0] run_inc;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign run_inc  = {1'b0, run_r} + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    route_nxt = route_r;
    led0_nxt  = led0_r;
    led1_nxt  = led1_r;
    start_nxt = 1'b0;
    if (in_kind == KIND_BYTE) begin
      unique case (phase_r)
        PH_E:     phase_nxt = (in_data_byte == CH_E) ? PH_T : PH_G;
        PH_T:     phase_nxt = (in_data_byte == CH_T) ? PH_SP : PH_G;
        PH_SP:    phase_nxt = (in_data_byte == CH_SPACE) ? PH_SLASH : PH_G;
        PH_SLASH: phase_nxt = (in_data_byte == CH_SLASH) ? PH_ROUTE : PH_G;
        PH_ROUTE: begin
          run_nxt   = 3'd0;
          phase_nxt = PH_HDR;
          if (in_data_byte == CH_S) begin
            route_nxt = ROUTE_STATUS;
          end else if (in_data_byte == CH_ZERO) begin
            route_nxt = ROUTE_REDIRECT;
            phase_nxt = PH_LED0;
          end else if (in_data_byte == CH_ONE) begin
            route_nxt = ROUTE_REDIRECT;
            phase_nxt = PH_LED1;
          end else if (in_data_byte == CH_SPACE || is_newline(in_data_byte)) begin
            route_nxt = ROUTE_MAIN;
          end else begin
            route_nxt = ROUTE_NOT_FOUND;
          end
        end
        PH_LED0: begin
          if (in_data_byte == CH_ONE) begin
            led0_nxt = 1'b1;
          end else if (in_data_byte == CH_ZERO) begin
            led0_nxt = 1'b0;
          end
          run_nxt   = 3'd0;
          phase_nxt = PH_HDR;
        end
        PH_LED1: begin
          if (in_data_byte == CH_ONE) begin
            led1_nxt = 1'b1;
          end else if (in_data_byte == CH_ZERO) begin
            led1_nxt = 1'b0;
          end
          run_nxt   = 3'd0;
          phase_nxt = PH_HDR;
        end
        PH_HDR: begin
          if (is_newline(in_data_byte)) begin
            if (run_inc >= END_COUNT) begin
              run_nxt   = 3'd0;
              phase_nxt = PH_WAIT;
              start_nxt = 1'b1;
            end else begin
              run_nxt = run_inc[2:0];
            end
          end else begin
            run_nxt = 3'd0;
          end
        end
        PH_WAIT: phase_nxt = PH_WAIT;
        default: phase_nxt = (in_data_byte == CH_G) ? PH_E : PH_G;
      endcase
    end else if (phase_r == PH_WAIT && !in_tx_busy_level) begin
      phase_nxt = PH_G;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_G;
      run_r       <= 3'd0;
      route_r     <= ROUTE_MAIN;
      led0_r      <= 1'b0;
      led1_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        run_r   <= run_nxt;
        route_r <= route_nxt;
        led0_r  <= led0_nxt;
        led1_r  <= led1_nxt;
        start_r <= start_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_route       = route_r;
  assign out_led_zero    = led0_r;
  assign out_led_one     = led1_r;
  assign out_start_pulse = start_r;

endmodule

// ===== design/hrrp_checker.sv =====
module hrrp_checker
  import hrrp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_kind,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_route,
  input logic       out_led_zero,
  input logic       out_led_one,
  input logic       out_start_pulse
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_route)
      && $stable(out_led_zero) && $stable(out_led_one) && $stable(out_start_pulse))
    else $error("stalled result item changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  a_status_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_STATUS |=> out_valid && !out_start_pulse)
    else $error("status sample produced a start pulse or no result");

  a_status_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_STATUS |=> $stable(out_route)
      && $stable(out_led_zero) && $stable(out_led_one))
    else $error("status sample changed the route or an LED");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind http_request_route_parser hrrp_checker u_hrrp_checker (.*);

// ===== tb/http_request_route_parser_tb.sv =====
`timescale 1ns / 100ps

module http_request_route_parser_tb;
  import hrrp_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 150;

  typedef struct packed {
    route_t route;
    logic   led_zero;
    logic   led_one;
    logic   start_pulse;
  } parser_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_kind = KIND_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_tx_busy_level = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_route;
  logic       out_led_zero;
  logic       out_led_one;
  logic       out_start_pulse;

  parser_result_t expected_results[$];

  phase_t     m_phase = PH_G;
  logic [2:0] m_newline_run = '0;
  route_t     m_route = ROUTE_MAIN;
  logic       m_led_zero = 1'b0;
  logic       m_led_one = 1'b0;

  bit idle_en = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int items_sent = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int start_pulses = 0;
  int errors = 0;
  int quiet_cycles = 0;

  http_request_route_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .in_tx_busy_level (in_tx_busy_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_route        (out_route),
    .out_led_zero     (out_led_zero),
    .out_led_one      (out_led_one),
    .out_start_pulse  (out_start_pulse)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_line_end(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  task automatic parser_model_step(input logic k, input logic [7:0] c, input logic busy);
    logic start;
    start = 1'b0;
    if (k == KIND_BYTE) begin
      case (m_phase)
        PH_E:     m_phase = (c == CH_E) ? PH_T : PH_G;
        PH_T:     m_phase = (c == CH_T) ? PH_SP : PH_G;
        PH_SP:    m_phase = (c == CH_SPACE) ? PH_SLASH : PH_G;
        PH_SLASH: m_phase = (c == CH_SLASH) ? PH_ROUTE : PH_G;
        PH_ROUTE: begin
          if (c == CH_S) begin
            m_route = ROUTE_STATUS;
            m_newline_run = '0;
            m_phase = PH_HDR;
          end else if (c == CH_ZERO) begin
            m_route = ROUTE_REDIRECT;
            m_phase = PH_LED0;
          end else if (c == CH_ONE) begin
            m_route = ROUTE_REDIRECT;
            m_phase = PH_LED1;
          end else if (c == CH_SPACE || is_line_end(c)) begin
            m_route = ROUTE_MAIN;
            m_newline_run = '0;
            m_phase = PH_HDR;
          end else begin
            m_route = ROUTE_NOT_FOUND;
            m_newline_run = '0;
            m_phase = PH_HDR;
          end
        end
        PH_LED0: begin
          if (c == CH_ONE) m_led_zero = 1'b1;
          else if (c == CH_ZERO) m_led_zero = 1'b0;
          m_newline_run = '0;
          m_phase = PH_HDR;
        end
        PH_LED1: begin
          if (c == CH_ONE) m_led_one = 1'b1;
          else if (c == CH_ZERO) m_led_one = 1'b0;
          m_newline_run = '0;
          m_phase = PH_HDR;
        end
        PH_HDR: begin
          if (is_line_end(c)) begin
            if (int'(m_newline_run) + 1 >= HEADER_END_COUNT_DEF) begin
              m_newline_run = '0;
              m_phase = PH_WAIT;
              start = 1'b1;
            end else begin
              m_newline_run = m_newline_run + 3'd1;
            end
          end else begin
            m_newline_run = '0;
          end
        end
        PH_WAIT: ;
        default: m_phase = (c == CH_G) ? PH_E : PH_G;
      endcase
    end else if (m_phase == PH_WAIT && busy == 1'b0) begin
      m_phase = PH_G;
    end
    expected_results.push_back(parser_result_t'{m_route, m_led_zero, m_led_one, start});
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      parser_model_step(in_kind, in_data_byte, in_tx_busy_level);
    end
  end

  always @(posedge clk) begin : check_results
    parser_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("Result item arrived with nothing expected");
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_start_pulse === 1'b1) start_pulses++;
        if (out_route !== want.route) begin
          $error("route: expected %0d, got %0d", want.route, out_route);
          errors++;
        end
        if (out_led_zero !== want.led_zero) begin
          $error("led_zero: expected %0d, got %0d", want.led_zero, out_led_zero);
          errors++;
        end
        if (out_led_one !== want.led_one) begin
          $error("led_one: expected %0d, got %0d", want.led_one, out_led_one);
          errors++;
        end
        if (out_start_pulse !== want.start_pulse) begin
          $error("start_pulse: expected %0d, got %0d", want.start_pulse, out_start_pulse);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timed out after %0d cycles with no item accepted", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic k, input logic [7:0] c, input logic busy);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_data_byte <= c;
    in_tx_busy_level <= busy;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(KIND_BYTE, c, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_status(input logic busy);
    send_item(KIND_STATUS, 8'($urandom), busy);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line_end();
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic send_request(input logic [7:0] route_ch, input logic [7:0] led_ch,
                              input int hdr_len, input int wait_len);
    requests_sent++;
    send_text("GET /");
    send_byte(route_ch);
    if (route_ch == CH_ZERO || route_ch == CH_ONE) send_byte(led_ch);
    repeat (hdr_len) begin
      if ($urandom_range(0, 3) == 0) send_line_end();
      else send_byte(8'($urandom));
    end
    repeat (HEADER_END_COUNT_DEF) send_line_end();
    repeat (wait_len) begin
      if ($urandom_range(0, 1)) send_byte(8'($urandom));
      else send_status(1'b1);
    end
    send_status(1'b0);
  endtask

  task automatic random_request();
    logic [7:0] route_ch;
    logic [7:0] led_ch;
    case ($urandom_range(0, 6))
      0:       route_ch = CH_S;
      1:       route_ch = CH_SPACE;
      2:       route_ch = CH_CR;
      3:       route_ch = CH_LF;
      4:       route_ch = CH_ZERO;
      5:       route_ch = CH_ONE;
      default: route_ch = 8'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0:       led_ch = CH_ZERO;
      1:       led_ch = CH_ONE;
      default: led_ch = 8'($urandom);
    endcase
    send_request(route_ch, led_ch, $urandom_range(0, 6), $urandom_range(0, 3));
  endtask

  task automatic test_edge_items();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_status(1'b1);
    send_status(1'b0);
  endtask

  task automatic test_led_request();
    send_text("GET /01");
    send_text("\r\n\r\n");
    send_byte(CH_G);
    send_status(1'b1);
    send_status(1'b0);
  endtask

  task automatic test_prefix_mismatch();
    send_text("GEX");
    send_text("GGE");
  endtask

  task automatic test_random_traffic();
    string prefix;
    prefix = "GET /";
    while (items_sent < 560) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          for (int i = 0; i < $urandom_range(1, 4); i++) send_byte(prefix[i]);
          send_byte(8'($urandom));
        end
        3, 4, 5: begin
          repeat ($urandom_range(1, 4)) send_item(1'($urandom_range(0, 1)), 8'($urandom),
                                                   1'($urandom_range(0, 1)));
        end
        default: random_request();
      endcase
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (2) random_request();
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    repeat (5) random_request();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_items();
    test_led_request();
    test_prefix_mismatch();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d items, among them %0d complete requests,", items_sent,
             requests_sent);
    $display("and checked %0d result items, %0d with a start pulse.", results_checked,
             start_pulses);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
